@@ sv/prs_pkg.sv @@
`timescale 1ns / 1ps

package prs_pkg;

  localparam int MAX_FACTORS = 16;
  localparam int DATA_W      = 64;
  localparam int CNT_W       = $clog2(MAX_FACTORS + 1);
  localparam int IDX_W       = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
  localparam int BIT_W       = $clog2(DATA_W);

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FSEL,
    S_DIV,
    S_PSTEP,
    S_MUL,
    S_OUT
  } state_t;

  // (a + b) mod m for a, b < m.
  function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
    word_t room;
    room = m - b;
    return (a >= room) ? (a - room) : (a + b);
  endfunction

endpackage

@@ sv/primitive_root_search.sv @@
`timescale 1ns / 1ps

// Smallest primitive root modulo p.
// Input channel (in_valid/in_ready): each transaction carries the modulus and
// optionally one distinct prime factor of p-1 (in_factor_valid). The
// transaction with in_last_factor set closes the list and starts the search;
// the modulus of that transaction is used. Up to prs_pkg::MAX_FACTORS factors
// are held, further ones are dropped.
// Result channel (out_valid/out_ready): one transaction with out_root per
// search, the first candidate x in 2..p-2 with x^((p-1)/q) != 1 mod p for all
// factors q, or the fallback (1 for p of 1 or 2, 2 for 3, 3 for 4, else 0).
// Timing: every factor test runs a bit-serial divider and a
// square-and-multiply power built on one bit-serial modular multiplier
// that serves both squares and products, and a whole search costs one test
// times factors times rejected candidates. For p below four no search runs:
// the machine enters S_OUT, loads the fallback there and then offers the
// result. Factor-only transactions are taken back to back while idle. Only one search is in flight;
// in_ready is low from the closing transaction until the result has been
// taken, and the result is held while out_ready is low.
// Reset empties the factor list and returns to idle.
module primitive_root_search (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [63:0]             in_modulus,
  input  logic [63:0]             in_prime_factor,
  input  logic                    in_factor_valid,
  input  logic                    in_last_factor,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [63:0]             out_root
);

  prs_pkg::state_t state_r, state_nxt;

  prs_pkg::word_t store_r [prs_pkg::MAX_FACTORS];
  logic [prs_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [prs_pkg::CNT_W-1:0] idx_r, idx_nxt;

  prs_pkg::word_t p_r, p_nxt, phi;
  prs_pkg::word_t x_r, x_nxt;
  prs_pkg::word_t root_r, root_nxt;
  logic           rej_r, rej_nxt;

  // Divider: quotient shifts in where the dividend shifts out.
  prs_pkg::word_t  dq_r, dq_nxt;
  prs_pkg::word_t  rem_r, rem_nxt;
  logic [64:0]     rem_sh;

  // Power and multiplier.
  prs_pkg::word_t  e_r, e_nxt;
  prs_pkg::word_t  res_r, res_nxt;
  prs_pkg::word_t  b_r, b_nxt;
  prs_pkg::word_t  ma_r, ma_nxt;
  prs_pkg::word_t  mb_r, mb_nxt;
  prs_pkg::word_t  acc_r, acc_nxt;
  logic            phase_r, phase_nxt;
  logic            sq_r, sq_nxt;
  logic            did_res_r, did_res_nxt;
  logic [prs_pkg::BIT_W-1:0] bit_r, bit_nxt;

  logic            in_acc;
  logic            store_we;
  prs_pkg::word_t  cur_q;
  prs_pkg::word_t  fallback;

  assign in_acc   = in_valid && in_ready;
  assign store_we = in_acc && in_factor_valid &&
                    (count_r < prs_pkg::CNT_W'(prs_pkg::MAX_FACTORS));
  assign phi      = p_r - 64'd1;
  assign cur_q    = store_r[idx_r[prs_pkg::IDX_W-1:0]];
  assign rem_sh   = {rem_r, dq_r[63]};

  always_comb begin
    case (p_r)
      64'd1, 64'd2: fallback = 64'd1;
      64'd3:        fallback = 64'd2;
      64'd4:        fallback = 64'd3;
      default:      fallback = 64'd0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    p_nxt       = p_r;
    x_nxt       = x_r;
    root_nxt    = root_r;
    rej_nxt     = rej_r;
    dq_nxt      = dq_r;
    rem_nxt     = rem_r;
    e_nxt       = e_r;
    res_nxt     = res_r;
    b_nxt       = b_r;
    ma_nxt      = ma_r;
    mb_nxt      = mb_r;
    acc_nxt     = acc_r;
    phase_nxt   = phase_r;
    sq_nxt      = sq_r;
    did_res_nxt = did_res_r;
    bit_nxt     = bit_r;
    case (state_r)
      prs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (store_we) begin
            count_nxt = count_r + 1'b1;
          end
          if (in_last_factor) begin
            p_nxt   = in_modulus;
            idx_nxt = '0;
            rej_nxt = 1'b0;
            if (in_modulus < 64'd4) begin
              root_nxt  = '0;
              state_nxt = prs_pkg::S_OUT;
              // Fallback resolved below once p_r holds the modulus.
              rej_nxt   = 1'b1;
            end else begin
              state_nxt = prs_pkg::S_SCAN;
            end
          end
        end
      end
      prs_pkg::S_SCAN: begin
        if (idx_r == count_r) begin
          idx_nxt = '0;
          x_nxt   = 64'd2;
          if (rej_r) begin
            root_nxt  = fallback;
            state_nxt = prs_pkg::S_OUT;
          end else begin
            state_nxt = prs_pkg::S_FSEL;
          end
        end else begin
          if (cur_q > phi) begin
            rej_nxt = 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      prs_pkg::S_FSEL: begin
        if (idx_r == count_r) begin
          root_nxt  = x_r;
          rej_nxt   = 1'b0;
          state_nxt = prs_pkg::S_OUT;
        end else if (cur_q == '0) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          dq_nxt    = phi;
          rem_nxt   = '0;
          bit_nxt   = '0;
          state_nxt = prs_pkg::S_DIV;
        end
      end
      prs_pkg::S_DIV: begin
        if (rem_sh >= {1'b0, cur_q}) begin
          rem_nxt = prs_pkg::word_t'(rem_sh - {1'b0, cur_q});
          dq_nxt  = {dq_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[63:0];
          dq_nxt  = {dq_r[62:0], 1'b0};
        end
        bit_nxt = bit_r + 1'b1;
        if (bit_r == '1) begin
          e_nxt       = dq_nxt;
          res_nxt     = 64'd1;
          b_nxt       = x_r;
          did_res_nxt = 1'b0;
          state_nxt   = prs_pkg::S_PSTEP;
        end
      end
      prs_pkg::S_PSTEP: begin
        if (e_r == '0) begin
          if (res_r == 64'd1) begin
            x_nxt   = x_r + 64'd1;
            idx_nxt = '0;
            if (x_nxt >= phi) begin
              root_nxt  = fallback;
              state_nxt = prs_pkg::S_OUT;
            end else begin
              state_nxt = prs_pkg::S_FSEL;
            end
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = prs_pkg::S_FSEL;
          end
        end else begin
          acc_nxt   = '0;
          bit_nxt   = '0;
          phase_nxt = 1'b0;
          state_nxt = prs_pkg::S_MUL;
          if (e_r[0] && !did_res_r) begin
            ma_nxt = res_r;
            mb_nxt = b_r;
            sq_nxt = 1'b0;
          end else begin
            ma_nxt = b_r;
            mb_nxt = b_r;
            sq_nxt = 1'b1;
          end
        end
      end
      prs_pkg::S_MUL: begin
        // Doubling on one cycle, conditional add of ma on the next.
        if (!phase_r) begin
          acc_nxt   = prs_pkg::add_mod(acc_r, acc_r, p_r);
          phase_nxt = 1'b1;
        end else begin
          if (mb_r[63]) begin
            acc_nxt = prs_pkg::add_mod(acc_r, ma_r, p_r);
          end
          mb_nxt    = {mb_r[62:0], 1'b0};
          phase_nxt = 1'b0;
          bit_nxt   = bit_r + 1'b1;
          if (bit_r == '1) begin
            state_nxt = prs_pkg::S_PSTEP;
            if (sq_r) begin
              b_nxt       = acc_nxt;
              e_nxt       = {1'b0, e_r[63:1]};
              did_res_nxt = 1'b0;
            end else begin
              res_nxt     = acc_nxt;
              did_res_nxt = 1'b1;
            end
          end
        end
      end
      prs_pkg::S_OUT: begin
        if (rej_r) begin
          root_nxt = fallback;
          rej_nxt  = 1'b0;
        end else if (out_ready) begin
          count_nxt = '0;
          state_nxt = prs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = prs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state_r == prs_pkg::S_IDLE);
    out_valid = (state_r == prs_pkg::S_OUT) && !rej_r;
    out_root  = root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prs_pkg::S_IDLE;
      count_r <= '0;
      rej_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rej_r   <= rej_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    p_r       <= p_nxt;
    x_r       <= x_nxt;
    root_r    <= root_nxt;
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    e_r       <= e_nxt;
    res_r     <= res_nxt;
    b_r       <= b_nxt;
    ma_r      <= ma_nxt;
    mb_r      <= mb_nxt;
    acc_r     <= acc_nxt;
    phase_r   <= phase_nxt;
    sq_r      <= sq_nxt;
    did_res_r <= did_res_nxt;
    bit_r     <= bit_nxt;
    if (store_we) begin
      store_r[count_r[prs_pkg::IDX_W-1:0]] <= in_prime_factor;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= prs_pkg::CNT_W'(prs_pkg::MAX_FACTORS))
    else $error("factor count above store depth");

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == prs_pkg::S_MUL |-> acc_r < p_r && ma_r < p_r)
    else $error("multiplier operand not reduced");

  a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == prs_pkg::S_PSTEP |-> res_r < p_r && b_r < p_r)
    else $error("power state not reduced");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");
`endif

endmodule

@@ bench/primitive_root_search_tb.sv @@
`timescale 1ns / 1ps

module primitive_root_search_tb;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_modulus;
  logic [63:0] in_prime_factor;
  logic        in_factor_valid;
  logic        in_last_factor;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_root;

  primitive_root_search u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_modulus(in_modulus), .in_prime_factor(in_prime_factor),
    .in_factor_valid(in_factor_valid), .in_last_factor(in_last_factor),
    .out_valid(out_valid), .out_ready(out_ready), .out_root(out_root)
  );

  typedef struct {
    logic [63:0] p;
    logic [63:0] q;
    bit          fv;
    bit          last;
    bit          typed;
    logic [63:0] root;
  } stim_row_t;

  // Predictor state: our own copy of the factor list.
  logic [63:0] held_factors[prs_pkg::MAX_FACTORS];
  int          held_count;
  logic [63:0] root_queue[$];
  int          errors;
  longint      cycle_count;
  longint      cycle_budget;
  longint      power_tests;
  bit          hold_req;
  bit          burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mod_add(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] room;
    room = m - b;
    return (a >= room) ? (a - room) : (a + b);
  endfunction

  function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] acc;
    acc = '0;
    for (int i = 63; i >= 0; i--) begin
      acc = mod_add(acc, acc, m);
      if (b[i]) acc = mod_add(acc, a, m);
    end
    return acc;
  endfunction

  function automatic logic [63:0] mod_pow(logic [63:0] x, logic [63:0] e, logic [63:0] m);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd1 % m;
    b = x % m;
    while (e != 0) begin
      if (e[0]) r = mod_mul(r, b, m);
      b = mod_mul(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [63:0] search_root(logic [63:0] p);
    logic [63:0] phi;
    bit          blocked;
    bit          ok;
    phi = p - 1;
    blocked = 1'b0;
    if (p >= 4) begin
      for (int i = 0; i < held_count; i++)
        if (held_factors[i] > phi) blocked = 1'b1;
      if (!blocked) begin
        for (logic [63:0] x = 2; x < phi; x++) begin
          ok = 1'b1;
          for (int i = 0; i < held_count && ok; i++) begin
            if (held_factors[i] != 0) begin
              power_tests++;
              if (mod_pow(x, phi / held_factors[i], p) == 64'd1) ok = 1'b0;
            end
          end
          if (ok) return x;
        end
      end
    end
    if (p == 1 || p == 2) return 64'd1;
    if (p == 3) return 64'd2;
    if (p == 4) return 64'd3;
    return 64'd0;
  endfunction

  // Drives one transaction, waits for acceptance and records what it should cause.
  task automatic send_item(logic [63:0] p, logic [63:0] q, bit fv, bit last,
                           bit typed, logic [63:0] typed_root);
    int          gap;
    logic [63:0] r;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_modulus      <= p;
    in_prime_factor <= q;
    in_factor_valid <= fv;
    in_last_factor  <= last;
    do @(posedge clk); while (!in_ready);
    if (fv && held_count < prs_pkg::MAX_FACTORS) begin
      held_factors[held_count] = q;
      held_count++;
    end
    cycle_budget += 20;
    if (last) begin
      power_tests = 0;
      r = search_root(p);
      held_count = 0;
      cycle_budget += power_tests * 20000 + 5000;
      if (typed && r != typed_root)
        $display("%0t: table row disagrees with predictor: %h vs %h", $time, typed_root, r);
      root_queue.push_back(typed ? typed_root : r);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (root_queue.size() != 0);
  endtask

  // Result side.
  initial begin
    int w;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        w = burst ? 0 : $urandom_range(0, 8);
        if (w > 0) begin
          out_ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (root_queue.size() == 0) begin
        $display("%0t: unexpected root transaction, actual %h", $time, out_root);
        errors++;
      end else begin
        if (out_root !== root_queue[0]) begin
          $display("%0t: root mismatch, expected %h actual %h", $time, root_queue[0], out_root);
          errors++;
        end
        void'(root_queue.pop_front());
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 4 * cycle_budget + 200000) begin
        $display("primitive_root_search_tb failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t   rows[$];
    logic [63:0] p;
    logic [63:0] n;
    int          seq;
    int          items;
    int          kind;
    int          nf;
    logic [63:0] facs[$];

    errors = 0;
    held_count = 0;
    cycle_budget = 0;
    hold_req = 1'b0;
    burst = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_modulus = '0;
    in_prime_factor = '0;
    in_factor_valid = 1'b0;
    in_last_factor = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows = '{
      '{64'd0, 64'd0, 1'b0, 1'b1, 1'b1, 64'd0},
      '{64'd1, 64'd0, 1'b0, 1'b1, 1'b1, 64'd1},
      '{64'd2, 64'd0, 1'b0, 1'b1, 1'b1, 64'd1},
      '{64'd3, 64'd0, 1'b0, 1'b1, 1'b1, 64'd2},
      '{64'd4, 64'd0, 1'b0, 1'b1, 1'b1, 64'd2},
      '{64'd0, 64'd2, 1'b1, 1'b0, 1'b0, 64'd0},
      '{64'd7, 64'd3, 1'b1, 1'b1, 1'b1, 64'd3},
      '{64'd0, 64'd0, 1'b1, 1'b0, 1'b0, 64'd0},
      '{64'd5, 64'd2, 1'b1, 1'b1, 1'b1, 64'd2},
      '{64'd7, 64'd9, 1'b1, 1'b1, 1'b1, 64'd0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 64'd0},
      '{64'hFFFF_FFFF_FFFF_FFC5, 64'd2, 1'b1, 1'b1, 1'b0, 64'd0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 64'd0},
      '{64'd13, 64'd2, 1'b1, 1'b0, 1'b0, 64'd0},
      '{64'd13, 64'd3, 1'b1, 1'b0, 1'b0, 64'd0},
      '{64'd13, 64'd0, 1'b0, 1'b1, 1'b0, 64'd0}
    };
    foreach (rows[i])
      send_item(rows[i].p, rows[i].q, rows[i].fv, rows[i].last, rows[i].typed, rows[i].root);

    // Store full: two real factors, padding zeros, then rejecting factors that get dropped.
    send_item(64'd9, 64'd2, 1'b1, 1'b0, 1'b0, '0);
    send_item(64'd9, 64'd3, 1'b1, 1'b0, 1'b0, '0);
    repeat (14) send_item({$urandom, $urandom}, 64'd0, 1'b1, 1'b0, 1'b0, '0);
    send_item(64'd1, 64'd100, 1'b1, 1'b0, 1'b0, '0);
    send_item(64'd7, 64'd100, 1'b1, 1'b1, 1'b0, '0);

    items = 0;
    seq = 0;
    while (items < 64) begin
      seq++;
      if (seq % 8 == 0) burst = ~burst;
      if (seq == 5) hold_req = 1'b1;
      if (seq == 12) drain();
      kind = $urandom_range(0, 9);
      facs.delete();
      if (kind < 7) begin
        // Well-formed: a small prime with the true factors of p-1.
        do begin
          p = $urandom_range(5, 60);
          n = 1;
          for (int d = 2; d * d <= p; d++) if (p % d == 0) n = 0;
        end while (n == 0);
        n = p - 1;
        for (int d = 2; d <= n; d++)
          if (n % d == 0) begin
            facs.push_back(d);
            while (n % d == 0) n = n / d;
          end
      end else if (kind < 9) begin
        p = $urandom_range(0, 14);
        nf = $urandom_range(0, 2);
        repeat (nf) facs.push_back($urandom_range(0, 16));
      end else begin
        // A factor at least p: every candidate is rejected at once.
        p = {$urandom, $urandom};
        facs.push_back(p);
        facs.push_back({$urandom, $urandom});
      end
      for (int i = 0; i < facs.size(); i++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b0, 1'b0, '0);
          items++;
        end
        if (i == facs.size() - 1 && $urandom_range(0, 1) == 1) begin
          send_item(p, facs[i], 1'b1, 1'b1, 1'b0, '0);
          items++;
          facs.delete();
          break;
        end
        send_item({$urandom, $urandom}, facs[i], 1'b1, 1'b0, 1'b0, '0);
        items++;
      end
      if (facs.size() != 0 || kind >= 7 || seq % 2 == 0) begin
        if (facs.size() != 0 || kind >= 7)
          send_item(p, {$urandom, $urandom}, 1'b0, 1'b1, 1'b0, '0);
        else
          send_item(p, {$urandom, $urandom}, 1'b0, 1'b1, 1'b0, '0);
        items++;
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (errors == 0 && root_queue.size() == 0) begin
      $display("primitive_root_search_tb passed");
    end else begin
      $display("primitive_root_search_tb failed");
    end
    $finish;
  end

endmodule
